/* rtl/core/rcc_pkg.sv */
// rcc_pkg: word types, register indexes and q16.16 saturating helpers
// for the capped cone intersector; no dependencies
package rcc_pkg;

	localparam int CW = 32;
	localparam int FRAC = 16;
	localparam int DW = 31;
	localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MIN_DIST_EXCL = 32'sd6553;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_TAN_SQ = 3'd3;
	localparam logic [2:0] REG_CAP_TOP = 3'd4;
	localparam logic [2:0] REG_CAP_BOTTOM = 3'd5;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0] best_dist;
		logic best_valid;
	} in_word_t;

	typedef struct packed {
		logic [30:0] dist_out;
		logic dist_valid;
		logic [1:0] hit_count;
	} out_word_t;

	// clamp a wide signed value into the symmetric range
	function automatic logic signed [CW-1:0] sat_w(input logic signed [CW+1:0] v);
		logic signed [CW+1:0] m;
		m = CW'(SAT_MAX);
		if (v > m) sat_w = SAT_MAX;
		else if (v < -m) sat_w = -SAT_MAX;
		else sat_w = v[CW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] fadd(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		fadd = sat_w(CW'(0) + {{2{a[CW-1]}}, a} + {{2{b[CW-1]}}, b});
	endfunction

	function automatic logic signed [CW-1:0] fsub(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		fsub = sat_w({{2{a[CW-1]}}, a} - {{2{b[CW-1]}}, b});
	endfunction

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
		mag = v[CW-1] ? CW'(-v) : v;
	endfunction

	// truncating magnitude product, saturated
	function automatic logic signed [CW-1:0] fmul(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic [2*CW-1:0] p;
		logic [2*CW-1:0] q;
		logic signed [CW-1:0] r;
		p = mag(a) * mag(b);
		q = p >> FRAC;
		r = (q > (2*CW)'(SAT_MAX)) ? SAT_MAX : q[CW-1:0];
		fmul = (a[CW-1] ^ b[CW-1]) ? -r : r;
	endfunction

endpackage

/* rtl/core/ray_capped_cone_intersect_core.sv */
// ray_capped_cone_intersect_core: top level of the capped cone intersector
// depends on rcc_pkg, rcc_div, rcc_sqrt
//
//   channel  | handshake           | word
//   ---------+---------------------+------------
//   in       | in_valid / in_stall | in_word_t
//   out      | out_valid/out_stall | out_word_t
//   cfg      | cfg_we              | cfg_index, cfg_data
//
// one word per cycle while no stall holds the output; the result passes through
// four front stages, the cap dividers (48 stages, the 24-stage sqrt sits behind
// a 24-stage delay), four cap stages, the body dividers (48) and three end stages
// one global enable: a stall at the output freezes every stage, nothing lost
// reset clears the valid pipe and loads register defaults
module ray_capped_cone_intersect_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rcc_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rcc_pkg::out_word_t out_data,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int CW = rcc_pkg::CW;
	typedef logic signed [CW-1:0] fx_t;
	localparam int DL = CW + rcc_pkg::FRAC;
	localparam int SL = DL / 2;

	fx_t cx_q, cy_q, cz_q, t2_q, top_q, bot_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			t2_q <= 32'sd65536; top_q <= 32'sd65536; bot_q <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				rcc_pkg::REG_CENTER_X: cx_q <= cfg_data;
				rcc_pkg::REG_CENTER_Y: cy_q <= cfg_data;
				rcc_pkg::REG_CENTER_Z: cz_q <= cfg_data;
				rcc_pkg::REG_TAN_SQ: t2_q <= {1'b0, cfg_data[30:0]};
				rcc_pkg::REG_CAP_TOP: top_q <= cfg_data;
				rcc_pkg::REG_CAP_BOTTOM: bot_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances unless a finished word is held at the output
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	function automatic fx_t clip(input fx_t v);
		clip = (v == {1'b1, {(CW-1){1'b0}}}) ? -rcc_pkg::SAT_MAX : v;
	endfunction

	// ray state that every later stage needs
	typedef struct packed {
		fx_t ox, oy, oz, dx, dy, dz, top, bot, t2;
		logic [30:0] best;
		logic bv;
	} ray_t;

	// s1: center subtract and clamp
	ray_t r_s1; logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1.ox <= rcc_pkg::fsub(clip(in_data.origin_x), clip(cx_q));
			r_s1.oy <= rcc_pkg::fsub(clip(in_data.origin_y), clip(cy_q));
			r_s1.oz <= rcc_pkg::fsub(clip(in_data.origin_z), clip(cz_q));
			r_s1.dx <= clip(in_data.dir_x);
			r_s1.dy <= clip(in_data.dir_y);
			r_s1.dz <= clip(in_data.dir_z);
			r_s1.top <= -clip(top_q);
			r_s1.bot <= clip(bot_q);
			r_s1.t2 <= t2_q;
			r_s1.best <= in_data.best_dist;
			r_s1.bv <= in_data.best_valid;
		end
	end

	// s2: first-level products
	ray_t r_s2; logic v_s2;
	fx_t dxx_s2, dzz_s2, dyy_s2, oxd_s2, ozd_s2, oyd_s2, oxx_s2, ozz_s2, oyy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s2 <= r_s1;
			dxx_s2 <= rcc_pkg::fmul(r_s1.dx, r_s1.dx);
			dzz_s2 <= rcc_pkg::fmul(r_s1.dz, r_s1.dz);
			dyy_s2 <= rcc_pkg::fmul(r_s1.dy, r_s1.dy);
			oxd_s2 <= rcc_pkg::fmul(r_s1.ox, r_s1.dx);
			ozd_s2 <= rcc_pkg::fmul(r_s1.oz, r_s1.dz);
			oyd_s2 <= rcc_pkg::fmul(r_s1.oy, r_s1.dy);
			oxx_s2 <= rcc_pkg::fmul(r_s1.ox, r_s1.ox);
			ozz_s2 <= rcc_pkg::fmul(r_s1.oz, r_s1.oz);
			oyy_s2 <= rcc_pkg::fmul(r_s1.oy, r_s1.oy);
		end
	end

	// s3: tan_sq scaling and sums
	ray_t r_s3; logic v_s3;
	fx_t a_s3, h_s3, c_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r_s2;
			a_s3 <= rcc_pkg::fsub(rcc_pkg::fadd(dxx_s2, dzz_s2),
				rcc_pkg::fmul(r_s2.t2, dyy_s2));
			h_s3 <= rcc_pkg::fsub(rcc_pkg::fadd(oxd_s2, ozd_s2),
				rcc_pkg::fmul(r_s2.t2, oyd_s2));
			c_s3 <= rcc_pkg::fsub(rcc_pkg::fadd(oxx_s2, ozz_s2),
				rcc_pkg::fmul(r_s2.t2, oyy_s2));
		end
	end

	// s4: discriminant
	ray_t r_s4; logic v_s4;
	fx_t a_s4, h_s4, disc_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s4 <= r_s3;
			a_s4 <= a_s3;
			h_s4 <= h_s3;
			disc_s4 <= rcc_pkg::fsub(rcc_pkg::fmul(h_s3, h_s3), rcc_pkg::fmul(a_s3, c_s3));
		end
	end

	// cap path: divides run in parallel with the square root
	typedef struct packed {
		ray_t r;
		fx_t a, h;
		logic bodyok;
	} sq_t;
	fx_t tt_num, tb_num, tt_q, tb_q;
	sq_t sq_in, sq_out;
	sq_t sq_d [DL+1];
	assign tt_num = rcc_pkg::fsub(r_s4.top, r_s4.oy);
	assign tb_num = rcc_pkg::fsub(r_s4.bot, r_s4.oy);
	assign sq_in = '{r: r_s4, a: a_s4, h: h_s4,
		bodyok: (disc_s4 > 0) && (a_s4 != '0)};

	rcc_div u_div_top (.clk(clk), .en(en), .num(tt_num), .den(r_s4.dy), .quo(tt_q));
	rcc_div u_div_bot (.clk(clk), .en(en), .num(tb_num), .den(r_s4.dy), .quo(tb_q));

	// ray data rides beside the dividers
	assign sq_d[0] = sq_in;
	for (genvar i = 0; i < DL; i++) begin : g_sqd
		always_ff @(posedge clk) if (en) sq_d[i+1] <= sq_d[i];
	end

	// square root over a matching delay: pad to divider length
	logic [CW-1:0] root_raw;
	fx_t disc_d [DL-SL+1];
	rcc_sqrt u_sqrt (.clk(clk), .en(en), .v(disc_d[DL-SL]), .root(root_raw));
	assign disc_d[0] = disc_s4;
	for (genvar i = 0; i < DL - SL; i++) begin : g_dd
		always_ff @(posedge clk) if (en) disc_d[i+1] <= disc_d[i];
	end
	assign sq_out = sq_d[DL];

	// s5: register divider outputs and root
	logic v_d [DL+1];
	assign v_d[0] = v_s4;
	for (genvar i = 0; i < DL; i++) begin : g_vd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else if (en) v_d[i+1] <= v_d[i];
		end
	end

	// cap hit point products (three stages)
	typedef struct packed {
		sq_t q;
		fx_t s, tt, tb;
	} cp_t;
	cp_t c_s5, c_s6, c_s7, c_s8;
	logic v_s5, v_s6, v_s7, v_s8;
	fx_t ixt_s6, izt_s6, ixb_s6, izb_s6, ppt_s6, ppb_s6;
	fx_t lt_s7, lb_s7, rt_s7, rb_s7;
	logic capt_s8, capb_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d[DL]; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= '{q: sq_out, s: fx_t'(root_raw), tt: tt_q, tb: tb_q};
			c_s6 <= c_s5;
			ixt_s6 <= rcc_pkg::fadd(c_s5.q.r.ox, rcc_pkg::fmul(c_s5.q.r.dx, c_s5.tt));
			izt_s6 <= rcc_pkg::fadd(c_s5.q.r.oz, rcc_pkg::fmul(c_s5.q.r.dz, c_s5.tt));
			ixb_s6 <= rcc_pkg::fadd(c_s5.q.r.ox, rcc_pkg::fmul(c_s5.q.r.dx, c_s5.tb));
			izb_s6 <= rcc_pkg::fadd(c_s5.q.r.oz, rcc_pkg::fmul(c_s5.q.r.dz, c_s5.tb));
			ppt_s6 <= rcc_pkg::fmul(c_s5.q.r.top, c_s5.q.r.top);
			ppb_s6 <= rcc_pkg::fmul(c_s5.q.r.bot, c_s5.q.r.bot);
			c_s7 <= c_s6;
			lt_s7 <= rcc_pkg::fadd(rcc_pkg::fmul(ixt_s6, ixt_s6), rcc_pkg::fmul(izt_s6, izt_s6));
			lb_s7 <= rcc_pkg::fadd(rcc_pkg::fmul(ixb_s6, ixb_s6), rcc_pkg::fmul(izb_s6, izb_s6));
			rt_s7 <= rcc_pkg::fmul(ppt_s6, c_s6.q.r.t2);
			rb_s7 <= rcc_pkg::fmul(ppb_s6, c_s6.q.r.t2);
			c_s8 <= c_s7;
			capt_s8 <= (c_s7.q.r.dy != '0) && (lt_s7 < rt_s7);
			capb_s8 <= (c_s7.q.r.dy != '0) && (lb_s7 < rb_s7);
		end
	end

	// body roots: two dividers on -h +- s, cap results ride alongside
	typedef struct packed {
		ray_t r;
		fx_t tt, tb;
		logic bodyok, capt, capb;
	} bd_t;
	bd_t bd_in, bd_out;
	bd_t bd_d [DL+1];
	fx_t n0, n1, r0_q, r1_q;
	assign n0 = rcc_pkg::fadd(-c_s8.q.h, c_s8.s);
	assign n1 = rcc_pkg::fsub(-c_s8.q.h, c_s8.s);
	assign bd_in = '{r: c_s8.q.r, tt: c_s8.tt, tb: c_s8.tb,
		bodyok: c_s8.q.bodyok, capt: capt_s8, capb: capb_s8};
	rcc_div u_div_r0 (.clk(clk), .en(en), .num(n0), .den(c_s8.q.a), .quo(r0_q));
	rcc_div u_div_r1 (.clk(clk), .en(en), .num(n1), .den(c_s8.q.a), .quo(r1_q));
	assign bd_d[0] = bd_in;
	for (genvar i = 0; i < DL; i++) begin : g_bdd
		always_ff @(posedge clk) if (en) bd_d[i+1] <= bd_d[i];
	end
	assign bd_out = bd_d[DL];

	logic v_e [DL+1];
	assign v_e[0] = v_s8;
	for (genvar i = 0; i < DL; i++) begin : g_ve
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_e[i+1] <= 1'b0;
			else if (en) v_e[i+1] <= v_e[i];
		end
	end

	// s9: hit y of both roots
	bd_t b_s9, b_s10;
	fx_t r0_s9, r1_s9, y0_s9, y1_s9;
	logic v_s9, v_s10, in0_s10, in1_s10;
	fx_t r0_s10, r1_s10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_e[DL]; v_s10 <= v_s9;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b_s9 <= bd_out;
			r0_s9 <= r0_q;
			r1_s9 <= r1_q;
			y0_s9 <= rcc_pkg::fadd(bd_out.r.oy, rcc_pkg::fmul(bd_out.r.dy, r0_q));
			y1_s9 <= rcc_pkg::fadd(bd_out.r.oy, rcc_pkg::fmul(bd_out.r.dy, r1_q));
			b_s10 <= b_s9;
			r0_s10 <= r0_s9;
			r1_s10 <= r1_s9;
			in0_s10 <= b_s9.bodyok && (y0_s9 < b_s9.r.bot) && (y0_s9 > b_s9.r.top);
			in1_s10 <= b_s9.bodyok && (y1_s9 < b_s9.r.bot) && (y1_s9 > b_s9.r.top);
		end
	end

	// s11: offer the four candidates in order
	typedef struct packed {
		logic [30:0] best;
		logic v;
		logic ok;
	} of_t;
	function automatic of_t offer(input of_t st, input logic en_c, input fx_t t);
		of_t o;
		o = st;
		o.ok = 1'b0;
		if (en_c && t > rcc_pkg::MIN_DIST_EXCL && (!st.v || t[30:0] < st.best)) begin
			o.best = t[30:0];
			o.v = 1'b1;
			o.ok = 1'b1;
		end
		offer = o;
	endfunction

	logic v_out_q;
	rcc_pkg::out_word_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else if (en) v_out_q <= v_s10;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			of_t s0, s1, s2, s3, s4;
			s0 = '{best: b_s10.r.best, v: b_s10.r.bv, ok: 1'b0};
			s1 = offer(s0, in0_s10, r0_s10);
			s2 = offer(s1, in1_s10, r1_s10);
			s3 = offer(s2, b_s10.capt, b_s10.tt);
			s4 = offer(s3, b_s10.capb, b_s10.tb);
			out_q.dist_out <= s4.v ? s4.best : '0;
			out_q.dist_valid <= s4.v;
			out_q.hit_count <= 2'(s1.ok | s2.ok) + 2'(s3.ok | s4.ok);
		end
	end
	assign out_valid = v_out_q;
	assign out_data = out_q;
endmodule

/* rtl/core/rcc_div.sv */
// rcc_div: pipelined restoring q16.16 divider, one quotient bit per stage
// depends on rcc_pkg; the caller delays its side data by the same depth
module rcc_div (
	input logic clk,
	input logic en,
	input logic signed [rcc_pkg::CW-1:0] num,
	input logic signed [rcc_pkg::CW-1:0] den,
	output logic signed [rcc_pkg::CW-1:0] quo
);
	localparam int CW = rcc_pkg::CW;
	localparam int QB = CW + rcc_pkg::FRAC;
	logic [QB-1:0] n_s [QB+1];
	logic [CW:0] rem_s [QB+1];
	logic [CW-1:0] d_s [QB+1];
	logic neg_s [QB+1];
	logic z_s [QB+1];

	always_comb begin
		n_s[0] = {rcc_pkg::mag(num), {rcc_pkg::FRAC{1'b0}}};
		rem_s[0] = '0;
		d_s[0] = rcc_pkg::mag(den);
		neg_s[0] = num[CW-1] ^ den[CW-1];
		z_s[0] = (den == '0);
	end

	// quotient bits shift into n as dividend bits shift out
	for (genvar i = 0; i < QB; i++) begin : g_st
		logic [CW+1:0] tr;
		logic [CW+1:0] df;
		assign tr = {rem_s[i], n_s[i][QB-1]};
		assign df = tr - {2'b00, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= df[CW+1] ? tr[CW:0] : df[CW:0];
				n_s[i+1] <= {n_s[i][QB-2:0], ~df[CW+1]};
				d_s[i+1] <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				z_s[i+1] <= z_s[i];
			end
		end
	end

	always_comb begin
		logic signed [CW-1:0] m;
		m = (n_s[QB] > QB'(rcc_pkg::SAT_MAX)) ? rcc_pkg::SAT_MAX : n_s[QB][CW-1:0];
		if (z_s[QB]) quo = '0;
		else quo = neg_s[QB] ? -m : m;
	end
endmodule

/* rtl/core/rcc_sqrt.sv */
// rcc_sqrt: pipelined floor square root of a q16.16 value, one result bit per stage
// depends on rcc_pkg
module rcc_sqrt (
	input logic clk,
	input logic en,
	input logic signed [rcc_pkg::CW-1:0] v,
	output logic [rcc_pkg::CW-1:0] root
);
	localparam int XB = rcc_pkg::CW + rcc_pkg::FRAC;
	localparam int NS = XB / 2;
	logic [XB-1:0] x_s [NS+1];
	logic [XB/2+1:0] rem_s [NS+1];
	logic [NS-1:0] r_s [NS+1];

	always_comb begin
		x_s[0] = {v, {rcc_pkg::FRAC{1'b0}}};
		rem_s[0] = '0;
		r_s[0] = '0;
	end

	// digit-by-digit root, two radicand bits per stage
	for (genvar i = 0; i < NS; i++) begin : g_st
		logic [XB/2+1:0] tr;
		logic [XB/2+1:0] tv;
		assign tr = {rem_s[i][XB/2-1:0], x_s[i][XB-1:XB-2]};
		assign tv = {r_s[i], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1] <= x_s[i] << 2;
				rem_s[i+1] <= (tr >= tv) ? tr - tv : tr;
				r_s[i+1] <= {r_s[i][NS-2:0], tr >= tv};
			end
		end
	end
	assign root = rcc_pkg::CW'(r_s[NS]);
endmodule

/* rtl/core/rcc_checker.sv */
// rcc_port_checker: port-level checks on the capped cone intersector
// depends on rcc_pkg; bound to ray_capped_cone_intersect_core
module rcc_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rcc_pkg::out_word_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held word changed");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.dist_valid |-> out_data.dist_out == '0 && out_data.hit_count == 2'd0)
		else $error("no-hit word not clean");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hit_count != 2'd3)
		else $error("hit count out of range");
endmodule

bind ray_capped_cone_intersect_core rcc_port_checker u_rcc_port_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data));
